>>> design/olvl_pkg.sv
// ----------------------------------------------------------------------------
// olvl_pkg - price level order table shared definitions
// Sizes, codes and the result bundle passed from the controller to the
// output register.
// ----------------------------------------------------------------------------
package olvl_pkg;

  localparam int MAX_ORDERS = 64;
  localparam int IDX_W      = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int CNT_W      = $clog2(MAX_ORDERS + 1);
  localparam int KIND_W     = 2;
  localparam int ID_W       = 32;
  localparam int SIZE_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int ORDERS_W   = 7;
  localparam int ENTRY_W    = ID_W + SIZE_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_MODIFY = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_CALC,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   volume;
    logic [ORDERS_W-1:0] orders;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

endpackage

>>> design/order_book_price_level.sv
// ----------------------------------------------------------------------------
// order_book_price_level - price level order table
// Add, remove and modify resting orders by identifier; reports status,
// level volume and order count for every request.
// ----------------------------------------------------------------------------
// Each request runs through S_SCAN, S_DRAIN, S_CALC and S_COMMIT from transfer
// to result: the controller walks the entry RAM one slot per cycle through its
// single read port, then does the last compare, the volume subtraction and the
// write-back that waits for a free output register. A new request is taken as
// soon as the result sits in the output register, even if it is not yet
// taken. Valid bits live in flip-flops and clear at reset; no clearing pass.
module order_book_price_level (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [olvl_pkg::KIND_W-1:0]    in_kind,
  input  logic [olvl_pkg::ID_W-1:0]      in_order_id,
  input  logic [olvl_pkg::SIZE_W-1:0]    in_order_size,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [olvl_pkg::STATUS_W-1:0]  out_status,
  output logic [olvl_pkg::SIZE_W-1:0]    out_level_volume,
  output logic [olvl_pkg::ORDERS_W-1:0]  out_level_orders
);
  import olvl_pkg::*;

  logic               busy;
  logic               start;
  logic               out_free;
  logic               res_load;
  res_t               res;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               out_valid_r;
  res_t               out_r;

  assign in_stall = busy;
  assign start    = in_valid && !busy;
  assign out_free = !out_valid_r || !out_stall;

  olvl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .kind       (in_kind),
    .order_id   (in_order_id),
    .order_size (in_order_size),
    .busy       (busy),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res)
  );

  olvl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ORDERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_level_volume = out_r.volume;
  assign out_level_orders = out_r.orders;

endmodule

>>> design/olvl_ram.sv
// ----------------------------------------------------------------------------
// olvl_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module olvl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/olvl_ctrl.sv
// ----------------------------------------------------------------------------
// olvl_ctrl - order table controller
// Scans the entry RAM one slot per cycle, finds the matching order and the
// lowest free slot, then updates the table, total volume and order count.
// ----------------------------------------------------------------------------
module olvl_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [olvl_pkg::KIND_W-1:0]      kind,
  input  logic [olvl_pkg::ID_W-1:0]        order_id,
  input  logic [olvl_pkg::SIZE_W-1:0]      order_size,
  output logic                             busy,
  output olvl_pkg::ram_req_t               ram_req,
  input  logic [olvl_pkg::ENTRY_W-1:0]     ram_rdata,
  input  logic                             out_free,
  output logic                             res_load,
  output olvl_pkg::res_t                   res
);
  import olvl_pkg::*;

  state_t state_r, state_nxt;

  logic [KIND_W-1:0]     kind_r;
  logic [ID_W-1:0]       id_r;
  logic [SIZE_W-1:0]     size_r;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      idx_d_r;
  logic                  iss_r;
  logic                  found_r;
  logic [IDX_W-1:0]      slot_r;
  logic [SIZE_W-1:0]     hit_size_r;
  logic                  free_found_r;
  logic [IDX_W-1:0]      free_idx_r;
  logic [SIZE_W-1:0]     base_r;
  logic [SIZE_W-1:0]     total_r, total_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [MAX_ORDERS-1:0] valid_r, valid_nxt;

  logic [ID_W-1:0]       rd_id;
  logic [SIZE_W-1:0]     rd_size;
  logic                  last_idx;
  logic                  commit;
  logic [STATUS_W-1:0]   status;
  logic [CNT_W+ORDERS_W-1:0] count_ext;

  function automatic logic [SIZE_W-1:0] vol_add(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SIZE_W] ? {SIZE_W{1'b1}} : s[SIZE_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] vol_sub(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b);
    return (b > a) ? '0 : (a - b);
  endfunction

  assign rd_id    = ram_rdata[ENTRY_W-1:SIZE_W];
  assign rd_size  = ram_rdata[SIZE_W-1:0];
  assign last_idx = (idx_r == IDX_W'(MAX_ORDERS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_SCAN;
      S_SCAN:   if (last_idx) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_CALC;
      S_CALC:   state_nxt = S_COMMIT;
      S_COMMIT: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs and commit decision
  always_comb begin
    busy          = (state_r != S_IDLE);
    commit        = (state_r == S_COMMIT) && out_free;
    res_load      = commit;
    ram_req.raddr = idx_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = slot_r;
    ram_req.wdata = {id_r, size_r};
    status        = ST_DONE;
    total_nxt     = total_r;
    count_nxt     = count_r;
    valid_nxt     = valid_r;
    case (kind_r)
      KIND_ADD: begin
        if (found_r) begin
          status = ST_DUP;
        end else if (!free_found_r) begin
          status = ST_FULL;
        end else begin
          ram_req.we            = commit;
          ram_req.waddr         = free_idx_r;
          valid_nxt[free_idx_r] = 1'b1;
          count_nxt             = count_r + CNT_W'(1);
          total_nxt             = vol_add(base_r, size_r);
        end
      end
      KIND_REMOVE: begin
        // empty table reports success
        if (count_r == '0) begin
          status = ST_DONE;
        end else if (!found_r) begin
          status = ST_NOTFOUND;
        end else begin
          valid_nxt[slot_r] = 1'b0;
          count_nxt         = count_r - CNT_W'(1);
          total_nxt         = base_r;
        end
      end
      KIND_MODIFY: begin
        if (!found_r) begin
          status = ST_NOTFOUND;
        end else begin
          ram_req.we = commit;
          total_nxt  = vol_add(base_r, size_r);
        end
      end
      default: status = ST_DONE;
    endcase
    count_ext  = {{ORDERS_W{1'b0}}, count_nxt};
    res.status = status;
    res.volume = total_nxt;
    res.orders = count_ext[ORDERS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iss_r   <= 1'b0;
      total_r <= '0;
      count_r <= '0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      iss_r   <= (state_r == S_SCAN);
      if (commit) begin
        total_r <= total_nxt;
        count_r <= count_nxt;
        valid_r <= valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_d_r <= idx_r;
    if (start && state_r == S_IDLE) begin
      kind_r       <= kind;
      id_r         <= order_id;
      size_r       <= order_size;
      idx_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (state_r == S_SCAN && !last_idx) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      // compare stage: RAM data of the slot issued last cycle
      if (iss_r) begin
        if (valid_r[idx_d_r] && rd_id == id_r && !found_r) begin
          found_r    <= 1'b1;
          slot_r     <= idx_d_r;
          hit_size_r <= rd_size;
        end
        if (!valid_r[idx_d_r] && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= idx_d_r;
        end
      end
    end
    // take the old size off before the new one goes on
    if (state_r == S_CALC) begin
      if (found_r && (kind_r == KIND_REMOVE || kind_r == KIND_MODIFY)) begin
        base_r <= vol_sub(total_r, hit_size_r);
      end else begin
        base_r <= total_r;
      end
    end
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench - order_book_price_level verification
// A table of directed requests covers the empty, duplicate, not-found,
// saturated-volume and unknown-kind cases. Random fill and drain phases
// follow, which push the table to full and back to empty. Each result is
// checked field by field against its typed report or a local model of the
// order table. Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import olvl_pkg::*;

  localparam time CLK_PERIOD = 8ns;
  localparam int  RANDOM_ITEMS = 1200;
  localparam int  PHASE_LEN = 150;
  localparam int  WATCHDOG_LIMIT = 1000;
  localparam int  DRAIN_CYCLES = 80;
  localparam int  DIRECTED_ROWS = 22;
  // the block answers this kind with the current totals and no change
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

  typedef struct packed {
    status_t             status;
    logic [SIZE_W-1:0]   volume;
    logic [ORDERS_W-1:0] orders;
  } level_report_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
    bit                typed;
    level_report_t     report;
  } request_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind = '0;
  logic [ID_W-1:0]     in_order_id = '0;
  logic [SIZE_W-1:0]   in_order_size = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SIZE_W-1:0]   out_level_volume;
  logic [ORDERS_W-1:0] out_level_orders;

  // local copy of the order table
  bit                slot_used [MAX_ORDERS];
  logic [ID_W-1:0]   slot_id [MAX_ORDERS];
  logic [SIZE_W-1:0] slot_vol [MAX_ORDERS];
  logic [SIZE_W-1:0] book_volume = '0;
  int                book_count = 0;

  level_report_t report_q [$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  int            hold_left = 0;
  bit            quiet = 1'b0;

  // expected totals are typed in only where they are plain from the request
  request_row_t directed_rows [DIRECTED_ROWS] = '{
    '{KIND_REMOVE,  32'h5,        32'h0,        1'b1, '{ST_DONE,     32'h0,        7'd0}},
    '{KIND_MODIFY,  32'h5,        32'h0,        1'b1, '{ST_NOTFOUND, 32'h0,        7'd0}},
    '{KIND_UNKNOWN, 32'h0,        32'h0,        1'b1, '{ST_DONE,     32'h0,        7'd0}},
    '{KIND_ADD,     32'h0,        32'h0,        1'b1, '{ST_DONE,     32'h0,        7'd1}},
    '{KIND_ADD,     32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{ST_DONE,     32'hFFFFFFFF, 7'd2}},
    '{KIND_ADD,     32'h0,        32'h7,        1'b1, '{ST_DUP,      32'hFFFFFFFF, 7'd2}},
    '{KIND_ADD,     32'h12345678, 32'd100,      1'b1, '{ST_DONE,     32'hFFFFFFFF, 7'd3}},
    '{KIND_REMOVE,  32'hFFFFFFFF, 32'h0,        1'b1, '{ST_DONE,     32'h0,        7'd2}},
    '{KIND_REMOVE,  32'hDEAD,     32'h0,        1'b1, '{ST_NOTFOUND, 32'h0,        7'd2}},
    '{KIND_MODIFY,  32'h12345678, 32'hFFFFFFF0, 1'b1, '{ST_DONE,     32'hFFFFFFF0, 7'd2}},
    '{KIND_MODIFY,  32'h0,        32'h20,       1'b1, '{ST_DONE,     32'hFFFFFFFF, 7'd2}},
    '{KIND_UNKNOWN, 32'h0,        32'h0,        1'b1, '{ST_DONE,     32'hFFFFFFFF, 7'd2}},
    '{KIND_MODIFY,  32'hAAAAAAAA, 32'h1,        1'b1, '{ST_NOTFOUND, 32'hFFFFFFFF, 7'd2}},
    '{KIND_REMOVE,  32'h0,        32'h0,        1'b1, '{ST_DONE,     32'hFFFFFFDF, 7'd1}},
    '{KIND_REMOVE,  32'h12345678, 32'h0,        1'b1, '{ST_DONE,     32'h0,        7'd0}},
    '{KIND_ADD,     32'h55555555, 32'd1000,     1'b0, '0},
    '{KIND_ADD,     32'hAAAAAAAA, 32'd2000,     1'b0, '0},
    '{KIND_MODIFY,  32'h55555555, 32'd3,        1'b0, '0},
    '{KIND_REMOVE,  32'hAAAAAAAA, 32'hFFFFFFFF, 1'b0, '0},
    '{KIND_ADD,     32'h80000000, 32'h7FFFFFFF, 1'b0, '0},
    '{KIND_REMOVE,  32'h55555555, 32'h0,        1'b0, '0},
    '{KIND_REMOVE,  32'h80000000, 32'h0,        1'b0, '0}
  };

  order_book_price_level i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_order_id      (in_order_id),
    .in_order_size    (in_order_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_level_volume (out_level_volume),
    .out_level_orders (out_level_orders)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b);
    logic [SIZE_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[SIZE_W] ? '1 : sum[SIZE_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] floor_sub(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
    return (b > a) ? '0 : a - b;
  endfunction

  // applies one request to the local table and returns the level report
  function automatic level_report_t apply_request(input logic [KIND_W-1:0] kind,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [SIZE_W-1:0] size);
    level_report_t report;
    int hit;
    int vacant;
    hit = -1;
    vacant = -1;
    // downward walk leaves the lowest matching and lowest free slot
    for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_id[i] == id) hit = i;
      if (!slot_used[i]) vacant = i;
    end
    report.status = ST_DONE;
    case (kind)
      KIND_ADD: begin
        if (hit >= 0) begin
          report.status = ST_DUP;
        end else if (vacant < 0) begin
          report.status = ST_FULL;
        end else begin
          slot_used[vacant] = 1'b1;
          slot_id[vacant] = id;
          slot_vol[vacant] = size;
          book_count++;
          book_volume = sat_add(book_volume, size);
        end
      end
      KIND_REMOVE: begin
        // empty table reports success
        if (book_count != 0) begin
          if (hit < 0) begin
            report.status = ST_NOTFOUND;
          end else begin
            book_volume = floor_sub(book_volume, slot_vol[hit]);
            slot_used[hit] = 1'b0;
            book_count--;
          end
        end
      end
      KIND_MODIFY: begin
        if (hit < 0) begin
          report.status = ST_NOTFOUND;
        end else begin
          book_volume = sat_add(floor_sub(book_volume, slot_vol[hit]), size);
          slot_vol[hit] = size;
        end
      end
      default: ;
    endcase
    report.volume = book_volume;
    report.orders = ORDERS_W'(book_count);
    return report;
  endfunction

  // called at a rising edge; returns at the edge of the transfer
  task automatic issue_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                               input logic [SIZE_W-1:0] size, input bit typed,
                               input level_report_t typed_report);
    int gap;
    level_report_t predicted;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_order_id <= id;
    in_order_size <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(kind, id, size);
    report_q.insert(report_q.size(), typed ? typed_report : predicted);
  endtask

  initial begin
    int roll;
    int pick;
    bit filling;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0] id;
    logic [SIZE_W-1:0] size;
    filling = 1'b0;
    for (int i = 0; i < MAX_ORDERS; i++) slot_used[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r])
      issue_request(directed_rows[r].kind, directed_rows[r].id, directed_rows[r].size,
                    directed_rows[r].typed, directed_rows[r].report);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // alternate fill and drain phases so the table reaches full and empty
      if (n % PHASE_LEN == 0) filling = ~filling;
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 3) kind = KIND_UNKNOWN;
      else if (filling) kind = (roll < 70) ? KIND_ADD : (roll < 85) ? KIND_REMOVE : KIND_MODIFY;
      else kind = (roll < 20) ? KIND_ADD : (roll < 75) ? KIND_REMOVE : KIND_MODIFY;

      id = $urandom();
      // mostly resting orders for remove/modify, a few duplicates for add
      if (book_count != 0 &&
          $urandom_range(0, 9) < ((kind == KIND_ADD) ? 1 : 8)) begin
        pick = $urandom_range(0, book_count - 1);
        for (int i = 0; i < MAX_ORDERS; i++) begin
          if (slot_used[i]) begin
            if (pick == 0) id = slot_id[i];
            pick--;
          end
        end
      end

      case ($urandom_range(0, 3))
        0, 1:    size = $urandom_range(0, 4095);
        2:       size = $urandom();
        default: size = 32'hFFFFFFFF - $urandom_range(0, 255);
      endcase

      issue_request(kind, id, size, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("order_book_price_level test passed");
    end else begin
      $display("order_book_price_level test failed");
    end
    $finish;
  end

  // result check and receiver stall
  always @(posedge clk) begin
    level_report_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected transfer status=%0d volume=%h orders=%0d",
                 $time, out_status, out_level_volume, out_level_orders);
        mismatches++;
      end else begin
        want = report_q.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          mismatches++;
        end
        if (out_level_volume !== want.volume) begin
          $display("%0t: level_volume expected %h actual %h",
                   $time, want.volume, out_level_volume);
          mismatches++;
        end
        if (out_level_orders !== want.orders) begin
          $display("%0t: level_orders expected %0d actual %0d",
                   $time, want.orders, out_level_orders);
          mismatches++;
        end
      end
      hold_left = draw_wait();
      out_stall <= (hold_left != 0);
    end else if (out_valid && out_stall) begin
      hold_left--;
      out_stall <= (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("order_book_price_level test failed");
      $finish;
    end
  end

endmodule

>>> filelist.f
design/olvl_pkg.sv
design/olvl_ram.sv
design/olvl_ctrl.sv
design/order_book_price_level.sv
test/testbench.sv
